/* design/cosh_taylor_series_unit_defines.svh */
// assertion macros shared by the cosh series unit
// no dependencies; taken in by the control and top-level files
`ifndef COSH_TAYLOR_SERIES_UNIT_DEFINES_SVH
`define COSH_TAYLOR_SERIES_UNIT_DEFINES_SVH

// property that must hold at every clock edge, muted while in reset
`define CTS_CHECK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition on one edge implies a consequence on the next edge
`define CTS_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/cts_pkg.sv */
// shared widths, types and helper functions of the cosh series unit
// no dependencies; used by every other file of the block but the assertion header
`timescale 1ns / 1ps

package cts_pkg;

	// field widths
	localparam int XW    = 22;   // signed Q5.16 argument
	localparam int MAGW  = 21;   // clamped magnitude
	localparam int XSQW  = 41;   // square of the magnitude, Q32
	localparam int SUMW  = 60;   // unsigned Q28.32 result
	localparam int KW    = 5;    // term index and term limit

	// cell chain geometry: each cell holds one digit of the working product
	localparam int DW          = 8;
	localparam int NCELL       = 13;            // 104-bit product
	localparam int TCELLS      = 8;             // 64-bit term
	localparam int SHIFT_CELLS = 32 / DW;       // digits dropped by the 2^32 scaling
	localparam int MACW        = DW + XSQW;     // digit times square
	localparam int CYW         = MACW + 1 - DW; // carry handed to the next cell
	localparam int RW          = 12;            // divisor and remainder
	localparam int TERMW       = TCELLS * DW;
	localparam int CNTW        = $clog2(NCELL);

	typedef logic [DW-1:0]    digit_t;
	typedef logic [CYW-1:0]   cy_t;
	typedef logic [RW-1:0]    rem_t;
	typedef logic [XSQW-1:0]  xsq_t;
	typedef logic [MAGW-1:0]  mag_t;
	typedef logic [SUMW-1:0]  sum_t;
	typedef logic [TERMW-1:0] term_t;
	typedef logic [KW-1:0]    k_t;
	typedef logic [CNTW-1:0]  cnt_t;

	localparam k_t   MAX_TERMS      = 5'd30;
	localparam k_t   TERM_LIMIT_RST = 5'd10;
	localparam mag_t X_LIMIT        = 21'd1310720;
	localparam sum_t ONE_Q32        = sum_t'(1) << 32;
	localparam cnt_t LAST_CNT       = cnt_t'(NCELL - 1);

	// operation of every cell in a cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_MUL,
		CELL_DIV
	} cell_op_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_DIV,
		ST_UPD,
		ST_FIN
	} st_t;

	// sequencer to datapath
	typedef struct packed {
		logic     ready;
		cell_op_t op;
		logic     setup;
		logic     upd;
		logic     load_res;
		k_t       k;
	} ctl_t;

	// datapath to sequencer
	typedef struct packed {
		logic term_zero;
		logic slot_free;
	} sts_t;

	// series divisor (2k-1)*2k
	function automatic rem_t d_of_k(input k_t k);
		logic [KW:0] a;
		logic [KW:0] b;
		rem_t        p;
		b = {k, 1'b0};
		a = b - 1'b1;
		p = {{(RW-KW-1){1'b0}}, a} * {{(RW-KW-1){1'b0}}, b};
		return p;
	endfunction

endpackage

/* design/cts_if.sv */
// valid/ready channel interfaces for argument and result transactions
// depends on cts_pkg for the payload types
`timescale 1ns / 1ps

// argument channel
interface cts_arg_if;
	logic                           valid;
	logic                           ready;
	logic signed [cts_pkg::XW-1:0]  x_arg;

	modport source (output valid, output x_arg, input ready);
	modport sink   (input valid, input x_arg, output ready);
endinterface

// result channel
interface cts_res_if;
	logic                  valid;
	logic                  ready;
	cts_pkg::sum_t         cosh_value;

	modport source (output valid, output cosh_value, input ready);
	modport sink   (input valid, input cosh_value, output ready);
endinterface

/* design/cts_cell.sv */
// one cell of the product/quotient chain: digit multiply-accumulate with
// carry to the upper neighbour, radix-256 divide step with remainder to the
// lower neighbour; depends on cts_pkg
`timescale 1ns / 1ps

module cts_cell (
	input  logic              clk,
	input  cts_pkg::cell_op_t op,
	input  cts_pkg::xsq_t     xsq,
	input  cts_pkg::rem_t     dvs,
	input  cts_pkg::digit_t   tin,
	input  cts_pkg::cy_t      cy_in,
	input  cts_pkg::rem_t     rem_in,
	output cts_pkg::cy_t      cy_out,
	output cts_pkg::rem_t     rem_out,
	output cts_pkg::digit_t   q
);

	cts_pkg::digit_t tdig_q;
	cts_pkg::digit_t dig_q;
	cts_pkg::cy_t    cy_q;
	cts_pkg::rem_t   rem_q;
	cts_pkg::digit_t q_q;

	logic [cts_pkg::MACW-1:0] prod;
	logic [cts_pkg::MACW:0]   mac;
	cts_pkg::rem_t            r_fin;
	cts_pkg::digit_t          q_fin;

	// term digit times square plus carry from the lower neighbour
	assign prod = {{cts_pkg::XSQW{1'b0}}, tdig_q} * {{cts_pkg::DW{1'b0}}, xsq};
	assign mac  = {1'b0, prod} + {{cts_pkg::DW{1'b0}}, cy_in};

	// restoring division of {remainder from above, own digit}, one bit a step
	always_comb begin
		logic [cts_pkg::RW:0] trial;
		logic [cts_pkg::RW:0] diff;
		cts_pkg::rem_t        r;
		r     = rem_in;
		q_fin = '0;
		for (int i = cts_pkg::DW - 1; i >= 0; i--) begin
			trial = {r, dig_q[i]};
			diff  = trial - {1'b0, dvs};
			if (trial >= {1'b0, dvs}) begin
				q_fin[i] = 1'b1;
				r        = diff[cts_pkg::RW-1:0];
			end else begin
				r = trial[cts_pkg::RW-1:0];
			end
		end
		r_fin = r;
	end

	// cell registers
	always_ff @(posedge clk) begin
		unique case (op)
			cts_pkg::CELL_HOLD: begin
			end
			cts_pkg::CELL_LOAD: begin
				tdig_q <= tin;
			end
			cts_pkg::CELL_MUL: begin
				dig_q <= mac[cts_pkg::DW-1:0];
				cy_q  <= mac[cts_pkg::MACW:cts_pkg::DW];
			end
			cts_pkg::CELL_DIV: begin
				rem_q <= r_fin;
				q_q   <= q_fin;
			end
		endcase
	end

	assign cy_out  = cy_q;
	assign rem_out = rem_q;
	assign q       = q_q;

endmodule

/* design/cts_ctrl.sv */
// sequencer of the cosh series unit: argument intake, term loop over the
// cell chain, hand-off to the output register; depends on cts_pkg and the
// assertion macro header
`timescale 1ns / 1ps
`include "cosh_taylor_series_unit_defines.svh"

module cts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          arg_valid,
	input  cts_pkg::k_t   term_limit,
	input  cts_pkg::sts_t sts,
	output cts_pkg::ctl_t ctl
);

	cts_pkg::st_t  st_q;
	cts_pkg::st_t  st_d;
	cts_pkg::cnt_t cnt_q;
	cts_pkg::k_t   k_q;
	cts_pkg::k_t   lim_q;

	logic cnt_wrap;
	logic last_term;

	assign cnt_wrap  = (cnt_q == cts_pkg::LAST_CNT);
	assign last_term = (k_q == lim_q) || sts.term_zero;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			cts_pkg::ST_IDLE:  if (arg_valid) st_d = cts_pkg::ST_SETUP;
			cts_pkg::ST_SETUP: st_d = (lim_q == '0) ? cts_pkg::ST_FIN : cts_pkg::ST_MUL;
			cts_pkg::ST_MUL:   if (cnt_wrap) st_d = cts_pkg::ST_DIV;
			cts_pkg::ST_DIV:   if (cnt_wrap) st_d = cts_pkg::ST_UPD;
			cts_pkg::ST_UPD:   st_d = last_term ? cts_pkg::ST_FIN : cts_pkg::ST_MUL;
			cts_pkg::ST_FIN:   if (sts.slot_free) st_d = cts_pkg::ST_IDLE;
			default:           st_d = cts_pkg::ST_IDLE;
		endcase
	end

	// state, phase counter, term index and captured limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= cts_pkg::ST_IDLE;
			cnt_q <= '0;
			k_q   <= '0;
			lim_q <= '0;
		end else begin
			st_q <= st_d;
			if ((st_q == cts_pkg::ST_MUL || st_q == cts_pkg::ST_DIV) && !cnt_wrap) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (st_q == cts_pkg::ST_SETUP) begin
				k_q <= cts_pkg::k_t'(1);
			end else if (st_q == cts_pkg::ST_UPD && !last_term) begin
				k_q <= k_q + 1'b1;
			end
			if (st_q == cts_pkg::ST_IDLE && arg_valid) begin
				lim_q <= term_limit;
			end
		end
	end

	// outputs
	always_comb begin
		ctl          = '0;
		ctl.op       = cts_pkg::CELL_HOLD;
		ctl.k        = k_q;
		unique case (st_q)
			cts_pkg::ST_IDLE: ctl.ready = 1'b1;
			cts_pkg::ST_SETUP: begin
				ctl.op    = cts_pkg::CELL_LOAD;
				ctl.setup = 1'b1;
			end
			cts_pkg::ST_MUL: ctl.op = cts_pkg::CELL_MUL;
			cts_pkg::ST_DIV: ctl.op = cts_pkg::CELL_DIV;
			cts_pkg::ST_UPD: begin
				ctl.op  = cts_pkg::CELL_LOAD;
				ctl.upd = 1'b1;
			end
			cts_pkg::ST_FIN: ctl.load_res = sts.slot_free;
			default: begin
			end
		endcase
	end

	// term index stays within the captured limit while terms are formed
	`CTS_CHECK(a_k_in_range, clk, arst_n, (st_q == cts_pkg::ST_MUL) |-> (k_q != '0 && k_q <= lim_q), "term index outside limit")
	// a full multiply sweep hands over to a fresh divide sweep
	`CTS_CHECK_NEXT(a_mul_then_div, clk, arst_n, st_q == cts_pkg::ST_MUL && cnt_wrap, st_q == cts_pkg::ST_DIV && cnt_q == '0, "multiply sweep not followed by divide")
	// a finished sum waits while the output register is occupied
	`CTS_CHECK_NEXT(a_fin_waits, clk, arst_n, st_q == cts_pkg::ST_FIN && !sts.slot_free, st_q == cts_pkg::ST_FIN, "result left before output slot freed")

endmodule

/* design/cosh_taylor_series_unit.sv */
// Truncated Maclaurin series of cosh(x), sum of x^(2k)/(2k)! for k = 0..term_limit.
// Argument transactions arrive on arg (x_arg, signed Q5.16); |x| is clamped to 20.
// Result transactions leave on res (cosh_value, unsigned Q28.32) from an output
// register, so a new argument is taken while an earlier result still waits.
// cfg_we/cfg_wdata write term_limit; values above 30 saturate to 30.
// One item at a time: each term is one multiply sweep and one divide sweep over
// a chain of 13 cells plus one update step. The sum is complete after term_limit
// terms, or fewer once a term truncates to zero (all later terms are zero).
// Reset (arst_n low) empties the unit and the output register and sets
// term_limit to 10. While res.ready stays low a finished sum waits in the
// sequencer and arg.ready stays low until the output register frees.
// depends on cts_pkg, cts_if, cts_cell, cts_ctrl and the assertion header
`timescale 1ns / 1ps
`include "cosh_taylor_series_unit_defines.svh"

module cosh_taylor_series_unit (
	input  logic               clk,
	input  logic               arst_n,
	cts_arg_if.sink            arg,
	cts_res_if.source          res,
	input  logic               cfg_we,
	input  cts_pkg::k_t        cfg_wdata
);

	cts_pkg::ctl_t ctl;
	cts_pkg::sts_t sts;

	cts_pkg::k_t   term_limit_q;
	cts_pkg::mag_t mag_q;
	cts_pkg::xsq_t xsq_q;
	cts_pkg::rem_t d_q;
	cts_pkg::sum_t sum_q;
	cts_pkg::sum_t res_q;
	logic          res_valid_q;

	logic [cts_pkg::XW-1:0]     x_abs;
	cts_pkg::mag_t              mag;
	logic [2*cts_pkg::MAGW-1:0] sq_full;
	cts_pkg::term_t             term;

	cts_pkg::digit_t tin [cts_pkg::NCELL];
	cts_pkg::cy_t    cy  [cts_pkg::NCELL];
	cts_pkg::rem_t   rem [cts_pkg::NCELL];
	cts_pkg::digit_t qd  [cts_pkg::NCELL];

	// term limit register, saturating on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_limit_q <= cts_pkg::TERM_LIMIT_RST;
		end else if (cfg_we) begin
			term_limit_q <= (cfg_wdata > cts_pkg::MAX_TERMS) ? cts_pkg::MAX_TERMS : cfg_wdata;
		end
	end

	// sequencer
	cts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.arg_valid  (arg.valid),
		.term_limit (term_limit_q),
		.sts        (sts),
		.ctl        (ctl)
	);

	assign arg.ready     = ctl.ready;
	assign sts.slot_free = !res_valid_q || res.ready;
	assign sts.term_zero = ~|term;

	// magnitude of the argument, clamped to 20.0
	assign x_abs = arg.x_arg[cts_pkg::XW-1] ? (cts_pkg::XW'(0) - $unsigned(arg.x_arg))
	                                        : $unsigned(arg.x_arg);
	assign mag   = (x_abs > {1'b0, cts_pkg::X_LIMIT}) ? cts_pkg::X_LIMIT
	                                                  : x_abs[cts_pkg::MAGW-1:0];
	assign sq_full = mag_q * mag_q;

	// argument, square, divisor and running sum
	always_ff @(posedge clk) begin
		if (arg.valid && ctl.ready) begin
			mag_q <= mag;
		end
		if (ctl.setup) begin
			xsq_q <= sq_full[cts_pkg::XSQW-1:0];
			d_q   <= cts_pkg::d_of_k(cts_pkg::k_t'(1));
			sum_q <= cts_pkg::ONE_Q32;
		end else if (ctl.upd) begin
			d_q   <= cts_pkg::d_of_k(ctl.k + 1'b1);
			sum_q <= sum_q + term[cts_pkg::SUMW-1:0];
		end
	end

	// cell chain: carries run upward, remainders run downward
	for (genvar j = 0; j < cts_pkg::NCELL; j++) begin : g_cell
		cts_pkg::cy_t  cy_in;
		cts_pkg::rem_t rem_in;

		if (j == 0) begin : g_bottom
			assign cy_in = '0;
		end else begin : g_lower
			assign cy_in = cy[j-1];
		end

		if (j == cts_pkg::NCELL - 1) begin : g_top
			assign rem_in = '0;
		end else begin : g_upper
			assign rem_in = rem[j+1];
		end

		// term digits: one at bit 32 at the start, else quotient shifted down by 2^32
		if (j < cts_pkg::TCELLS) begin : g_term
			if (j == cts_pkg::SHIFT_CELLS) begin : g_one
				assign tin[j] = ctl.setup ? cts_pkg::digit_t'(1) : qd[j+cts_pkg::SHIFT_CELLS];
			end else begin : g_zero
				assign tin[j] = ctl.setup ? '0 : qd[j+cts_pkg::SHIFT_CELLS];
			end
			assign term[j*cts_pkg::DW +: cts_pkg::DW] = qd[j+cts_pkg::SHIFT_CELLS];
		end else begin : g_spare
			assign tin[j] = '0;
		end

		cts_cell u_cell (
			.clk     (clk),
			.op      (ctl.op),
			.xsq     (xsq_q),
			.dvs     (d_q),
			.tin     (tin[j]),
			.cy_in   (cy_in),
			.rem_in  (rem_in),
			.cy_out  (cy[j]),
			.rem_out (rem[j]),
			.q       (qd[j])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.load_res) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_res) begin
			res_q <= sum_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.cosh_value = res_q;

	// divisor in use belongs to the term being formed
	`CTS_CHECK(a_div_matches_k, clk, arst_n, (ctl.op == cts_pkg::CELL_DIV) |-> (d_q == cts_pkg::d_of_k(ctl.k)), "divisor out of step with term index")
	// a result is loaded only into a free output slot
	`CTS_CHECK(a_load_free_slot, clk, arst_n, ctl.load_res |-> (!res_valid_q || res.ready), "result overwrote a pending transaction")

endmodule
